// File: src/dns_reply_address_parser_top_assert.svh
// ----------------------------------------------------------------------------
// DNS reply address parser assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DNS_REPLY_ADDRESS_PARSER_TOP_ASSERT_SVH
`define DNS_REPLY_ADDRESS_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dnsp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DNSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dnsp: next-cycle check failed");

`endif

// File: src/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// DNS reply address parser package
// Types and constants shared by the parser modules and interfaces.
// ----------------------------------------------------------------------------
package dnsp_pkg;

  // Record and name constants.
  localparam logic [15:0] TypeA       = 16'd1;
  localparam logic [15:0] TypeAaaa    = 16'd28;
  localparam logic [15:0] ClassIn     = 16'd1;
  localparam logic [7:0]  PointerMark = 8'd192;

  // Address family codes of the configuration register.
  localparam logic [1:0] FamIpv4   = 2'd0;
  localparam logic [1:0] FamIpv6   = 2'd1;
  localparam logic [1:0] FamEither = 2'd2;

  // Address lengths in bytes.
  localparam logic [4:0] LenIpv4 = 5'd4;
  localparam logic [4:0] LenIpv6 = 5'd16;

  // Byte positions inside the fixed fields.
  localparam logic [3:0] HdrQdHi    = 4'd4;
  localparam logic [3:0] HdrQdLo    = 4'd5;
  localparam logic [3:0] HdrAnHi    = 4'd6;
  localparam logic [3:0] HdrAnLo    = 4'd7;
  localparam logic [3:0] HdrLast    = 4'd11;
  localparam logic [3:0] QFixLast   = 4'd3;
  localparam logic [3:0] AFixTypeEnd  = 4'd2;
  localparam logic [3:0] AFixClassEnd = 4'd4;
  localparam logic [3:0] AFixTtlEnd   = 4'd8;
  localparam logic [3:0] AFixLast   = 4'd9;
  localparam logic [3:0] PtrSecond  = 4'd1;

  // Parse phase, one-hot.
  typedef enum logic [7:0] {
    PhHeader = 8'b0000_0001,
    PhQName  = 8'b0000_0010,
    PhQFixed = 8'b0000_0100,
    PhAName  = 8'b0000_1000,
    PhAFixed = 8'b0001_0000,
    PhSkip   = 8'b0010_0000,
    PhAddr   = 8'b0100_0000,
    PhDone   = 8'b1000_0000
  } phase_e;

  // One result word.
  typedef struct packed {
    logic        status;
    logic [4:0]  address_length;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] ttl;
  } result_t;

endpackage

// File: src/dnsp_if.sv
// ----------------------------------------------------------------------------
// DNS reply address parser channel interfaces
// Valid/ready channels for message bytes, results and configuration.
// ----------------------------------------------------------------------------

// Message byte channel.
interface dnsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel.
interface dnsp_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [4:0]  address_length;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [31:0] ttl;

  modport source (output valid, output status, output address_length,
                  output address_high, output address_low, output ttl, input ready);
  modport sink   (input valid, input status, input address_length,
                  input address_high, input address_low, input ttl, output ready);
endinterface

// Configuration write channel.
interface dnsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] address_family;

  modport source (output valid, output address_family, input ready);
  modport sink   (input valid, input address_family, output ready);
endinterface

// File: src/dns_reply_address_parser_top.sv
// ----------------------------------------------------------------------------
// DNS reply address parser top level
// Finds the first wanted A or AAAA answer of a DNS reply, one byte a cycle unless bytes stall.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Word                                         Accepted
//   byte_i    in    data_byte, last_byte                         valid && ready
//   result_o  out   status, address_length, address_high/low,    valid && ready
//                   ttl
//   cfg_i     in    address_family                               valid && ready
//
// One byte is taken every cycle unless bytes stall; the parse state updates in that cycle.
// The result of a message is registered on its final byte and shows in the next cycle.
// Reset returns the parse to the header and the family register to "either".
// Bytes stall only while a result is held and the result sink is not ready.
// Configuration writes are always accepted.
//
module dns_reply_address_parser_top
  import dnsp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  dnsp_byte_if.sink     byte_i,
  dnsp_result_if.source result_o,
  dnsp_cfg_if.sink      cfg_i
);

  logic [1:0] family_q;
  logic       take;
  logic       in_ready;
  logic       res_load;
  result_t    res_next;
  result_t    res_held;

  // Address family register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= FamEither;
    end else if (cfg_i.valid) begin
      family_q <= cfg_i.address_family;
    end
  end

  // Byte handshake.
  assign byte_i.ready = in_ready;
  assign take         = byte_i.valid && in_ready;

  dnsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (byte_i.data_byte),
    .last_byte_i (byte_i.last_byte),
    .family_i    (family_q),
    .res_load_o  (res_load),
    .res_o       (res_next)
  );

  dnsp_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_next),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .res_o       (res_held),
    .in_ready_o  (in_ready)
  );

  assign result_o.status         = res_held.status;
  assign result_o.address_length = res_held.address_length;
  assign result_o.address_high   = res_held.address_high;
  assign result_o.address_low    = res_held.address_low;
  assign result_o.ttl            = res_held.ttl;

  // Checks.
  `include "dns_reply_address_parser_top_assert.svh"

  `DNSP_ASSERT_NXT(a_last_gives_result, take && byte_i.last_byte, result_o.valid)
  `DNSP_ASSERT_IMP(a_no_take_when_full, result_o.valid && !result_o.ready, !byte_i.ready)
  `DNSP_ASSERT_NXT(a_cfg_written, cfg_i.valid, family_q == $past(cfg_i.address_family))

endmodule

// File: src/dnsp_parser.sv
// ----------------------------------------------------------------------------
// DNS reply parse engine
// Walks header, questions and answers one byte per accepted word.
// ----------------------------------------------------------------------------
module dnsp_parser
  import dnsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic [1:0] family_i,
  output logic       res_load_o,
  output result_t    res_o
);

  phase_e       phase_q, phase_d;
  logic [3:0]   fbc_q, fbc_d;
  logic [15:0]  qd_q, qd_d;
  logic [15:0]  an_q, an_d;
  logic [7:0]   lbl_q, lbl_d;
  logic [15:0]  rtype_q, rtype_d;
  logic [15:0]  rclass_q, rclass_d;
  logic [31:0]  ttl_q, ttl_d;
  logic [15:0]  dlen_q, dlen_d;
  logic [127:0] addr_q, addr_d;
  logic         found_q, found_d;

  logic         name_done;
  logic [3:0]   name_fbc;
  logic [7:0]   name_lbl;
  logic [15:0]  qd_dec;
  logic [15:0]  an_dec;
  logic [15:0]  dlen_new;
  logic         is_a;
  logic         is_aaaa;
  logic         wanted;
  logic         bad_len;
  logic         res_is_a;

  assign qd_dec   = qd_q - 16'd1;
  assign an_dec   = an_q - 16'd1;
  assign dlen_new = {dlen_q[7:0], data_byte_i};

  // Record selection once the fixed answer fields are complete.
  assign is_a    = (rtype_q == TypeA);
  assign is_aaaa = (rtype_q == TypeAaaa);
  assign wanted  = (rclass_q == ClassIn) && (is_a || is_aaaa) &&
                   !(is_a && family_i == FamIpv6) && !(is_aaaa && family_i == FamIpv4);
  assign bad_len = (is_a && dlen_new != 16'd4) || (is_aaaa && dlen_new != 16'd16);

  // One byte of an owner name: labels, root byte or a compression pointer.
  always_comb begin
    name_done = 1'b0;
    name_fbc  = fbc_q;
    name_lbl  = lbl_q;
    if (fbc_q == PtrSecond) begin
      name_fbc  = 4'd0;
      name_done = 1'b1;
    end else if (lbl_q != 8'd0) begin
      name_lbl = lbl_q - 8'd1;
    end else if (data_byte_i == 8'd0) begin
      name_done = 1'b1;
    end else if (data_byte_i >= PointerMark) begin
      name_fbc = PtrSecond;
    end else begin
      name_lbl = data_byte_i;
    end
  end

  // Next state of the parse, result forming and end-of-message clear.
  always_comb begin
    phase_d  = phase_q;
    fbc_d    = fbc_q;
    qd_d     = qd_q;
    an_d     = an_q;
    lbl_d    = lbl_q;
    rtype_d  = rtype_q;
    rclass_d = rclass_q;
    ttl_d    = ttl_q;
    dlen_d   = dlen_q;
    addr_d   = addr_q;
    found_d  = found_q;

    if (take_i) begin
      unique case (phase_q)
        PhHeader: begin
          fbc_d = fbc_q + 4'd1;
          if (fbc_q == HdrQdHi) qd_d = {data_byte_i, 8'h00};
          if (fbc_q == HdrQdLo) qd_d = {qd_q[15:8], data_byte_i};
          if (fbc_q == HdrAnHi) an_d = {data_byte_i, 8'h00};
          if (fbc_q == HdrAnLo) an_d = {an_q[15:8], data_byte_i};
          if (fbc_q == HdrLast) begin
            fbc_d = 4'd0;
            lbl_d = 8'd0;
            if (qd_q != 16'd0) begin
              phase_d = PhQName;
            end else if (an_q == 16'd0) begin
              phase_d = PhDone;
            end else begin
              phase_d = PhAName;
            end
          end
        end
        PhQName, PhAName: begin
          fbc_d = name_fbc;
          lbl_d = name_lbl;
          if (name_done) begin
            fbc_d   = 4'd0;
            phase_d = (phase_q == PhQName) ? PhQFixed : PhAFixed;
          end
        end
        PhQFixed: begin
          fbc_d = fbc_q + 4'd1;
          if (fbc_q == QFixLast) begin
            fbc_d = 4'd0;
            lbl_d = 8'd0;
            qd_d  = qd_dec;
            if (qd_dec != 16'd0) begin
              phase_d = PhQName;
            end else if (an_q == 16'd0) begin
              phase_d = PhDone;
            end else begin
              phase_d = PhAName;
            end
          end
        end
        PhAFixed: begin
          if (fbc_q < AFixTypeEnd) begin
            rtype_d = {rtype_q[7:0], data_byte_i};
          end else if (fbc_q < AFixClassEnd) begin
            rclass_d = {rclass_q[7:0], data_byte_i};
          end else if (fbc_q < AFixTtlEnd) begin
            ttl_d = {ttl_q[23:0], data_byte_i};
          end else begin
            dlen_d = dlen_new;
          end
          fbc_d = fbc_q + 4'd1;
          if (fbc_q == AFixLast) begin
            fbc_d = 4'd0;
            if (!wanted) begin
              if (dlen_new == 16'd0) begin
                an_d  = an_dec;
                lbl_d = 8'd0;
                phase_d = (an_dec == 16'd0) ? PhDone : PhAName;
              end else begin
                phase_d = PhSkip;
              end
            end else if (bad_len) begin
              phase_d = PhDone;
            end else begin
              addr_d  = '0;
              phase_d = PhAddr;
            end
          end
        end
        PhSkip: begin
          dlen_d = dlen_q - 16'd1;
          if (dlen_q == 16'd1) begin
            an_d  = an_dec;
            fbc_d = 4'd0;
            lbl_d = 8'd0;
            phase_d = (an_dec == 16'd0) ? PhDone : PhAName;
          end
        end
        PhAddr: begin
          addr_d = {addr_q[119:0], data_byte_i};
          fbc_d  = fbc_q + 4'd1;
          dlen_d = dlen_q - 16'd1;
          if (dlen_q == 16'd1) begin
            found_d = 1'b1;
            phase_d = PhDone;
          end
        end
        PhDone: begin
          // Decision made: bytes are ignored until the final one.
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end

    // Result word from the state after this byte.
    res_is_a = (rtype_d == TypeA);
    res_o    = '0;
    if (found_d) begin
      res_o.status = 1'b0;
      res_o.ttl    = ttl_d;
      if (res_is_a) begin
        res_o.address_length = LenIpv4;
        res_o.address_high   = {addr_d[31:0], 32'd0};
      end else begin
        res_o.address_length = LenIpv6;
        res_o.address_high   = addr_d[127:64];
        res_o.address_low    = addr_d[63:0];
      end
    end else begin
      res_o.status = 1'b1;
    end

    // The final byte returns the parse to the header phase.
    if (take_i && last_byte_i) begin
      phase_d  = PhHeader;
      fbc_d    = 4'd0;
      qd_d     = 16'd0;
      an_d     = 16'd0;
      lbl_d    = 8'd0;
      rtype_d  = 16'd0;
      rclass_d = 16'd0;
      ttl_d    = 32'd0;
      dlen_d   = 16'd0;
      addr_d   = '0;
      found_d  = 1'b0;
    end
  end

  assign res_load_o = take_i && last_byte_i;

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      fbc_q    <= 4'd0;
      qd_q     <= 16'd0;
      an_q     <= 16'd0;
      lbl_q    <= 8'd0;
      rtype_q  <= 16'd0;
      rclass_q <= 16'd0;
      ttl_q    <= 32'd0;
      dlen_q   <= 16'd0;
      addr_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      qd_q     <= qd_d;
      an_q     <= an_d;
      lbl_q    <= lbl_d;
      rtype_q  <= rtype_d;
      rclass_q <= rclass_d;
      ttl_q    <= ttl_d;
      dlen_q   <= dlen_d;
      addr_q   <= addr_d;
      found_q  <= found_d;
    end
  end

endmodule

// File: src/dnsp_result_reg.sv
// ----------------------------------------------------------------------------
// DNS reply result register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module dnsp_result_reg
  import dnsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t res_o,
  output logic    in_ready_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Bytes may enter whenever the held word leaves in this cycle or none is held.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i)      valid_d = 1'b1;
  end

  // Control bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: verif/tb_dns_reply_address_parser_top.sv
// ----------------------------------------------------------------------------
// DNS reply address parser testbench
// Streams directed and random DNS reply messages into the parser. A byte-level
// predictor tracks the parse, and every result word is checked against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dns_reply_address_parser_top;
  import dnsp_pkg::*;

  localparam logic [15:0] TypeCname    = 16'd5;
  localparam int          SettleCycles = 8;
  localparam int          HoldCycles   = 400;
  localparam int          NumDirected  = 16;
  localparam result_t     ErrReply     = '{status: 1'b1, default: '0};

  typedef enum logic [1:0] {OcOpen, OcFound, OcError} outcome_e;
  typedef enum int {NmPointer, NmLabels, NmRoot, NmLabelsPtr, NmLong} name_e;

  // Shape of one generated message.
  typedef struct {
    logic [1:0]       family;
    logic [15:0]      qd;
    logic [15:0]      an;
    int               nrec;
    logic [1:0][15:0] rtype;
    logic [1:0][15:0] rclass;
    logic [1:0][15:0] rdlen;
    name_e            names;
    int               lng;
    int               cut;
    int               pad;
    int               fill;
    int               noise;
    logic             typed_err;
  } msg_t;

  logic clk_i;
  logic rst_ni;

  dnsp_byte_if   byte_ch ();
  dnsp_result_if reply_ch ();
  dnsp_cfg_if    cfg_ch ();

  dns_reply_address_parser_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (reply_ch),
    .cfg_i    (cfg_ch)
  );

  // Predicted parse state.
  logic [1:0]  pr_family;
  phase_e      pr_phase;
  logic [3:0]  pr_cnt;
  logic [15:0] pr_qleft;
  logic [15:0] pr_aleft;
  logic [7:0]  pr_lbl;
  logic [15:0] pr_rtype;
  logic [15:0] pr_rclass;
  logic [31:0] pr_rttl;
  logic [15:0] pr_dleft;
  logic [7:0]  pr_addr [16];
  outcome_e    pr_outcome;

  result_t     expected_replies [$];
  logic [7:0]  msg_q [$];
  msg_t        dir_tab [NumDirected];
  int          n_checked;
  int          n_errors;
  logic        hold_rx = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Return the predicted parse to the start of a message.
  task automatic clear_parse();
    pr_phase   = PhHeader;
    pr_cnt     = '0;
    pr_qleft   = '0;
    pr_aleft   = '0;
    pr_lbl     = '0;
    pr_rtype   = '0;
    pr_rclass  = '0;
    pr_rttl    = '0;
    pr_dleft   = '0;
    foreach (pr_addr[i]) pr_addr[i] = '0;
    pr_outcome = OcOpen;
  endtask

  task automatic decide_error();
    pr_outcome = OcError;
    pr_phase   = PhDone;
  endtask

  task automatic start_answers();
    pr_cnt = '0;
    pr_lbl = '0;
    if (pr_aleft == 0) decide_error();
    else pr_phase = PhAName;
  endtask

  task automatic next_record();
    pr_aleft = pr_aleft - 16'd1;
    start_answers();
  endtask

  // Takes one name byte; returns 1 when the name is complete.
  function automatic logic name_done(input logic [7:0] b);
    if (pr_cnt == PtrSecond) begin
      pr_cnt = '0;
      return 1'b1;
    end
    if (pr_lbl != 0) begin
      pr_lbl = pr_lbl - 8'd1;
      return 1'b0;
    end
    if (b == 8'd0) return 1'b1;
    if (b >= PointerMark) begin
      pr_cnt = PtrSecond;
      return 1'b0;
    end
    pr_lbl = b;
    return 1'b0;
  endfunction

  // Advance the predicted parse by one accepted byte word.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    result_t r;
    logic    is_a, is_aaaa, wanted;
    int      i;
    if (pr_outcome == OcOpen) begin
      case (pr_phase)
        PhHeader: begin
          if (pr_cnt == HdrQdHi) pr_qleft = {b, 8'h00};
          if (pr_cnt == HdrQdLo) pr_qleft = pr_qleft | {8'h00, b};
          if (pr_cnt == HdrAnHi) pr_aleft = {b, 8'h00};
          if (pr_cnt == HdrAnLo) pr_aleft = pr_aleft | {8'h00, b};
          if (pr_cnt != HdrLast) pr_cnt++;
          else begin
            pr_cnt = '0;
            pr_lbl = '0;
            if (pr_qleft != 0) pr_phase = PhQName;
            else start_answers();
          end
        end
        PhQName: begin
          if (name_done(b)) begin
            pr_cnt   = '0;
            pr_phase = PhQFixed;
          end
        end
        PhQFixed: begin
          if (pr_cnt != QFixLast) pr_cnt++;
          else begin
            pr_cnt   = '0;
            pr_lbl   = '0;
            pr_qleft = pr_qleft - 16'd1;
            if (pr_qleft != 0) pr_phase = PhQName;
            else start_answers();
          end
        end
        PhAName: begin
          if (name_done(b)) begin
            pr_cnt   = '0;
            pr_phase = PhAFixed;
          end
        end
        PhAFixed: begin
          if (pr_cnt < AFixTypeEnd) pr_rtype = {pr_rtype[7:0], b};
          else if (pr_cnt < AFixClassEnd) pr_rclass = {pr_rclass[7:0], b};
          else if (pr_cnt < AFixTtlEnd) pr_rttl = {pr_rttl[23:0], b};
          else pr_dleft = {pr_dleft[7:0], b};
          if (pr_cnt != AFixLast) pr_cnt++;
          else begin
            is_a    = (pr_rtype == TypeA);
            is_aaaa = (pr_rtype == TypeAaaa);
            wanted  = (pr_rclass == ClassIn) && (is_a || is_aaaa) &&
                      !(is_a && pr_family == FamIpv6) && !(is_aaaa && pr_family == FamIpv4);
            pr_cnt = '0;
            if (!wanted) begin
              if (pr_dleft == 0) next_record();
              else pr_phase = PhSkip;
            end else if ((is_a && pr_dleft != 16'(LenIpv4)) ||
                         (is_aaaa && pr_dleft != 16'(LenIpv6))) begin
              decide_error();
            end else begin
              foreach (pr_addr[k]) pr_addr[k] = '0;
              pr_phase = PhAddr;
            end
          end
        end
        PhSkip: begin
          pr_dleft = pr_dleft - 16'd1;
          if (pr_dleft == 0) next_record();
        end
        PhAddr: begin
          pr_addr[pr_cnt] = b;
          pr_cnt++;
          pr_dleft = pr_dleft - 16'd1;
          if (pr_dleft == 0) begin
            pr_outcome = OcFound;
            pr_phase   = PhDone;
          end
        end
        default: ;
      endcase
    end
    // The final byte of a message yields exactly one result word.
    if (last) begin
      r = '0;
      if (pr_outcome == OcFound) begin
        r.address_length = (pr_rtype == TypeA) ? LenIpv4 : LenIpv6;
        for (i = 0; i < 8; i++) begin
          r.address_high = {r.address_high[55:0], pr_addr[i]};
          r.address_low  = {r.address_low[55:0], pr_addr[i + 8]};
        end
        if (r.address_length == LenIpv4) begin
          r.address_high[31:0] = '0;
          r.address_low        = '0;
        end
        r.ttl = pr_rttl;
      end else begin
        r.status = 1'b1;
      end
      expected_replies.push_back(r);
      clear_parse();
    end
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  // Append one owner name in the requested encoding.
  task automatic add_name(input name_e nm, input int lng);
    int n;
    case (nm)
      NmPointer, NmRoot: ;
      NmLong: begin
        msg_q.push_back(8'(lng));
        repeat (lng) msg_q.push_back(8'($urandom));
      end
      default: begin
        repeat ($urandom_range(1, 2)) begin
          n = $urandom_range(1, 5);
          msg_q.push_back(8'(n));
          repeat (n) msg_q.push_back(8'($urandom));
        end
      end
    endcase
    if (nm == NmPointer || nm == NmLabelsPtr) begin
      msg_q.push_back(8'($urandom_range(192, 255)));
      msg_q.push_back(8'($urandom));
    end else begin
      msg_q.push_back(8'd0);
    end
  endtask

  // Lay out the bytes of one message.
  task automatic build_msg(input msg_t m);
    int i;
    msg_q.delete();
    if (m.noise > 0) begin
      repeat (m.noise) msg_q.push_back(8'($urandom));
    end else begin
      repeat (4) msg_q.push_back(8'($urandom));
      msg_q.push_back(m.qd[15:8]);
      msg_q.push_back(m.qd[7:0]);
      msg_q.push_back(m.an[15:8]);
      msg_q.push_back(m.an[7:0]);
      repeat (4) msg_q.push_back(8'($urandom));
      repeat ((m.qd > 3) ? 3 : m.qd) begin
        add_name(m.names, m.lng);
        repeat (4) msg_q.push_back(8'($urandom));
      end
      for (i = 0; i < m.nrec; i++) begin
        add_name(m.names, m.lng);
        msg_q.push_back(m.rtype[i][15:8]);
        msg_q.push_back(m.rtype[i][7:0]);
        msg_q.push_back(m.rclass[i][15:8]);
        msg_q.push_back(m.rclass[i][7:0]);
        repeat (4) msg_q.push_back(fill_byte(m.fill));
        msg_q.push_back(m.rdlen[i][15:8]);
        msg_q.push_back(m.rdlen[i][7:0]);
        repeat (m.rdlen[i]) msg_q.push_back(fill_byte(m.fill));
      end
      repeat (m.pad) msg_q.push_back(8'($urandom));
      repeat (m.cut) if (msg_q.size() > 1) void'(msg_q.pop_back());
    end
  endtask

  function automatic msg_t dir_row(input logic [1:0] fam, input logic [15:0] qd, an,
                                   input int nrec, input logic [15:0] t0, c0, l0,
                                   input logic [15:0] t1, c1, l1, input name_e nm,
                                   input int lng, cut, pad, fill, input logic typed);
    msg_t m;
    m.family    = fam;
    m.qd        = qd;
    m.an        = an;
    m.nrec      = nrec;
    m.rtype     = {t1, t0};
    m.rclass    = {c1, c0};
    m.rdlen     = {l1, l0};
    m.names     = nm;
    m.lng       = lng;
    m.cut       = cut;
    m.pad       = pad;
    m.fill      = fill;
    m.noise     = 0;
    m.typed_err = typed;
    return m;
  endfunction

  // Mostly well-formed replies with random content, some noise and broken ones.
  function automatic msg_t rand_msg();
    msg_t m;
    int   k;
    m.family = pr_family;
    if (!hold_rx && $urandom_range(0, 9) == 0) m.family = 2'($urandom_range(0, 3));
    m.noise = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : 0;
    m.qd = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
    m.an = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    m.nrec = (m.an > 2) ? 2 : int'(m.an);
    if ($urandom_range(0, 7) == 0) m.nrec = $urandom_range(0, 2);
    for (k = 0; k < 2; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m.rtype[k] = TypeA;
        4, 5, 6, 7: m.rtype[k] = TypeAaaa;
        8:          m.rtype[k] = TypeCname;
        default:    m.rtype[k] = 16'($urandom);
      endcase
      m.rclass[k] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : ClassIn;
      if (m.rtype[k] == TypeA) m.rdlen[k] = 16'(LenIpv4);
      else if (m.rtype[k] == TypeAaaa) m.rdlen[k] = 16'(LenIpv6);
      else m.rdlen[k] = 16'($urandom_range(0, 6));
      if ($urandom_range(0, 7) == 0) m.rdlen[k] = 16'($urandom_range(0, 20));
    end
    k = $urandom_range(0, 9);
    m.names     = (k == 9) ? NmLong : name_e'(k % 4);
    m.lng       = $urandom_range(64, 70);
    m.cut       = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 0;
    m.pad       = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    m.fill      = ($urandom_range(0, 19) == 0) ? 255 : -1;
    m.typed_err = 1'b0;
    return m;
  endfunction

  // Offer one byte word, with a random gap unless the stretch is calm.
  task automatic push_byte(input logic [7:0] b, input logic last, input logic calm);
    int gap;
    int r;
    r   = $urandom_range(0, 19);
    gap = (calm || r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
    predict_byte(b, last);
  endtask

  // Stop offering bytes until every expected result word has come back.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_family(input logic [1:0] v);
    settle();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.address_family <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pr_family = v;
  endtask

  task automatic send_msg(input msg_t m, input logic calm);
    if (m.family != pr_family) write_family(m.family);
    build_msg(m);
    foreach (msg_q[i]) push_byte(msg_q[i], i == msg_q.size() - 1, calm);
    // Error outcomes are known by inspection; they replace the prediction.
    if (m.typed_err) begin
      void'(expected_replies.pop_back());
      expected_replies.push_back(ErrReply);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want, got);
    if (got !== want) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_reply();
    result_t got;
    result_t want;
    got = {reply_ch.status, reply_ch.address_length, reply_ch.address_high,
           reply_ch.address_low, reply_ch.ttl};
    n_checked++;
    if (expected_replies.size() == 0) begin
      n_errors++;
      $display("%0t ns: result word with none expected, actual %h", $time, got);
    end else begin
      want = expected_replies.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("address_length", 64'(want.address_length), 64'(got.address_length));
      compare_field("address_high", want.address_high, got.address_high);
      compare_field("address_low", want.address_low, got.address_low);
      compare_field("ttl", 64'(want.ttl), 64'(got.ttl));
    end
  endtask

  // Receiver: checks each result word and throttles ready, with calm stretches.
  initial begin : receiver
    int rx_stall;
    int rx_cycles;
    rx_stall  = 0;
    rx_cycles = 0;
    reply_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rst_ni && reply_ch.valid && reply_ch.ready) check_reply();
      if (hold_rx) begin
        reply_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        reply_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        reply_ch.ready <= 1'b1;
        if ((rx_cycles / 256) % 4 != 0 && $urandom_range(0, 5) == 0) begin
          rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
        end
      end
    end
  end

  // One long hold-off on the result side so that the parser backs up.
  initial begin : receiver_hold
    wait (n_checked >= 17);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus: reset, directed messages, then random messages.
  initial begin : stimulus
    msg_t m;
    int   n_msgs;
    int   n_bytes;
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= '0;
    byte_ch.last_byte     <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.address_family <= FamEither;
    rst_ni                <= 1'b0;
    pr_family = FamEither;
    clear_parse();

    // Family, qd, an, records, then two records as type/class/rdlength,
    // names, long label length, cut, pad, fill and typed-error flag.
    // Header cut short after its first byte.
    dir_tab[0]  = dir_row(FamEither, 0, 1, 0, TypeA, ClassIn, 4, TypeA, ClassIn, 4,
                          NmPointer, 0, 11, 0, -1, 1'b1);
    // No answers: decided right after the question, trailing bytes ignored.
    dir_tab[1]  = dir_row(FamEither, 1, 0, 0, TypeA, ClassIn, 4, TypeA, ClassIn, 4,
                          NmLabels, 0, 0, 3, -1, 1'b1);
    // A record with all-ones address and TTL.
    dir_tab[2]  = dir_row(FamEither, 1, 1, 1, TypeA, ClassIn, 4, TypeA, ClassIn, 4,
                          NmPointer, 0, 0, 0, 255, 1'b0);
    // AAAA record with all-zero address and TTL.
    dir_tab[3]  = dir_row(FamEither, 0, 1, 1, TypeAaaa, ClassIn, 16, TypeA, ClassIn, 4,
                          NmLabels, 0, 0, 0, 0, 1'b0);
    // IPv4 only, the single answer is AAAA: answers run out.
    dir_tab[4]  = dir_row(FamIpv4, 1, 1, 1, TypeAaaa, ClassIn, 16, TypeA, ClassIn, 4,
                          NmRoot, 0, 0, 0, -1, 1'b1);
    // IPv6 only: the A record is skipped, the AAAA one is taken.
    dir_tab[5]  = dir_row(FamIpv6, 1, 2, 2, TypeA, ClassIn, 4, TypeAaaa, ClassIn, 16,
                          NmLabelsPtr, 0, 0, 0, -1, 1'b0);
    // Class other than IN is skipped.
    dir_tab[6]  = dir_row(FamIpv6, 0, 2, 2, TypeAaaa, 16'd3, 16, TypeAaaa, ClassIn, 16,
                          NmPointer, 0, 0, 0, -1, 1'b0);
    // A record with a bad address length.
    dir_tab[7]  = dir_row(FamEither, 1, 1, 1, TypeA, ClassIn, 5, TypeA, ClassIn, 4,
                          NmPointer, 0, 0, 5, -1, 1'b1);
    // AAAA record with an A-sized address.
    dir_tab[8]  = dir_row(FamEither, 0, 1, 1, TypeAaaa, ClassIn, 4, TypeA, ClassIn, 4,
                          NmLabels, 0, 0, 0, -1, 1'b1);
    // Message ends inside the address.
    dir_tab[9]  = dir_row(FamEither, 1, 1, 1, TypeAaaa, ClassIn, 16, TypeA, ClassIn, 4,
                          NmLabelsPtr, 0, 3, 0, -1, 1'b1);
    // Largest answer count, empty unwanted record ahead of the A record.
    dir_tab[10] = dir_row(FamEither, 0, 16'hFFFF, 2, TypeCname, ClassIn, 0, TypeA, ClassIn,
                          4, NmPointer, 0, 0, 0, -1, 1'b0);
    // Longest plain label length below the pointer mark.
    dir_tab[11] = dir_row(FamEither, 1, 1, 1, TypeA, ClassIn, 4, TypeA, ClassIn, 4,
                          NmLong, 191, 0, 0, -1, 1'b0);
    // Largest question count: the message ends among the questions.
    dir_tab[12] = dir_row(FamEither, 16'hFFFF, 1, 0, TypeA, ClassIn, 4, TypeA, ClassIn, 4,
                          NmLong, 64, 0, 0, -1, 1'b1);
    // Family value three behaves as either.
    dir_tab[13] = dir_row(2'd3, 1, 2, 2, TypeAaaa, ClassIn, 16, TypeA, ClassIn, 4,
                          NmLabels, 0, 0, 0, -1, 1'b0);
    // Junk after the chosen address is ignored.
    dir_tab[14] = dir_row(FamIpv4, 1, 2, 2, TypeCname, ClassIn, 3, TypeA, ClassIn, 4,
                          NmLabelsPtr, 0, 0, 6, -1, 1'b0);
    // Both answers unwanted: answers run out.
    dir_tab[15] = dir_row(FamIpv4, 0, 2, 2, TypeAaaa, ClassIn, 16, TypeCname, ClassIn, 2,
                          NmPointer, 0, 0, 0, -1, 1'b1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    n_bytes = 0;
    for (int k = 0; k < NumDirected; k++) begin
      send_msg(dir_tab[k], k % 2 == 0);
      n_bytes += msg_q.size();
    end

    n_msgs = 0;
    while (n_bytes < 1650) begin
      m = rand_msg();
      // Once, drain everything before going on.
      if (n_msgs == 2) settle();
      send_msg(m, n_msgs % 5 == 0);
      n_bytes += msg_q.size();
      n_msgs++;
    end

    settle();
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
